/* hw/rtl/fbvs_pkg.sv */
// Shared types and constants of the four-bone vertex skinning unit.
// No dependencies; every other file but fbvs_chan_if refers to it by scoped names.
`default_nettype none

package fbvs_pkg;

	localparam int WORDS_PER_BONE = 12;
	localparam int ROW_WORDS      = 4;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SKIN = 1'b1;

	localparam logic signed [63:0] ROUND_HALF = 64'sd32768;
	localparam logic [63:0]        DIV_BIAS   = 64'd127;
	localparam logic [63:0]        DIV_CONST  = 64'd255;
	localparam logic [55:0]        SAT_POS_Q  = 56'h0000007FFFFFFF;
	localparam logic [55:0]        SAT_NEG_Q  = 56'h00000080000000;
	localparam logic [31:0]        SAT_MAX    = 32'h7FFF_FFFF;
	localparam logic [31:0]        SAT_MIN    = 32'h8000_0000;

	// reciprocal of 3 for the word index split: floor(x/3) = (x*683) >> 11 for x < 1024
	localparam logic [19:0] RECIP3 = 20'd683;

	typedef struct packed {
		logic               command;
		logic [11:0]        palette_word_index;
		logic signed [31:0] palette_word_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] norm_x;
		logic signed [31:0] norm_y;
		logic signed [31:0] norm_z;
		logic [31:0]        bone_weights;
		logic [31:0]        bone_indices;
		logic               last_vertex;
	} vtx_in_t;

	typedef struct packed {
		logic signed [31:0] skinned_x;
		logic signed [31:0] skinned_y;
		logic signed [31:0] skinned_z;
		logic signed [31:0] skinned_nx;
		logic signed [31:0] skinned_ny;
		logic signed [31:0] skinned_nz;
		logic               batch_end;
	} skin_out_t;

	typedef logic [WORDS_PER_BONE-1:0][31:0] bone_row_t;

	typedef struct packed {
		logic       wr_ok;
		logic [8:0] wr_bone;
		logic [3:0] wr_elem;
		vtx_in_t    item;
	} q_entry_t;

endpackage

`default_nettype wire

/* hw/rtl/fbvs_chan_if.sv */
// Valid/ready channel carrying one word of a given payload type.
// No dependencies.
`default_nettype none

interface fbvs_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/four_bone_vertex_skinning_unit.sv */
// Top level of the four-bone linear blend skinning unit.
// Depends on fbvs_pkg, fbvs_chan_if, fbvs_front, fbvs_queue and fbvs_back.
`default_nettype none

// The unit keeps a palette of BONE_COUNT 3x4 bone matrices in Q16.16 and
// skins vertices against it. Load words (command 0) write one palette word
// and leave the queue whenever the back end advances; they give no output
// word. A vertex word steps through INFLUENCES influences (4 by default) in
// the back end, one at a time, because the palette has a single read port
// that delivers one whole bone row (12 words) per cycle while the output is
// not stalled, one row per influence. Vertices stream back to back; each
// gives one output word once its last influence has passed the row read,
// the products, the rounded transform, the weighting, the accumulator and
// the divide by 255. Influences with zero weight or a bone number at or above
// BONE_COUNT add nothing; weights are not renormalized. A palette word must
// be written before any vertex with a non-zero weight uses its bone. The
// input side keeps accepting into a four-entry queue while an output word
// waits, so the two sides stall independently.

module four_bone_vertex_skinning_unit #(
	parameter int BONE_COUNT = 256,
	parameter int INFLUENCES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	fbvs_chan_if.sink   vtx_in,
	fbvs_chan_if.source skin_out
);

	logic               q_full;
	logic               push;
	fbvs_pkg::q_entry_t push_entry;
	logic               head_vld;
	fbvs_pkg::q_entry_t head;
	logic               pop;

	// front: register the input word and split load indexes into bone/element
	fbvs_front #(
		.BONE_COUNT (BONE_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vtx_in     (vtx_in),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// queue: hold words in order so loads and vertices keep their sequence
	fbvs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.head_vld   (head_vld),
		.head       (head),
		.pop        (pop)
	);

	// back: write the palette, step through influences, blend and saturate
	fbvs_back #(
		.BONE_COUNT (BONE_COUNT),
		.INFLUENCES (INFLUENCES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_vld (head_vld),
		.head     (head),
		.pop      (pop),
		.skin_out (skin_out)
	);

endmodule

`default_nettype wire

/* hw/rtl/fbvs_front.sv */
// Front end: accepts input words, splits load word indexes into bone and element.
// Depends on fbvs_pkg and fbvs_chan_if.
`default_nettype none

module fbvs_front #(
	parameter int BONE_COUNT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	fbvs_chan_if.sink           vtx_in,
	input  logic                q_full,
	output logic                push,
	output fbvs_pkg::q_entry_t  push_entry
);

	logic               vld_s1;
	fbvs_pkg::q_entry_t entry_s1;
	logic [9:0]         quad;
	logic [19:0]        quad_prod;
	logic [8:0]         bone;
	logic [12:0]        elem_wide;
	logic               wr_ok;

	// word index / 12 = (index / 4) / 3
	assign quad      = vtx_in.data.palette_word_index[11:2];
	assign quad_prod = 20'(quad) * fbvs_pkg::RECIP3;
	assign bone      = quad_prod[19:11];
	assign elem_wide = {1'b0, vtx_in.data.palette_word_index}
		- 13'(bone) * 13'(fbvs_pkg::WORDS_PER_BONE);
	assign wr_ok     = {1'b0, vtx_in.data.palette_word_index}
		< 13'(BONE_COUNT * fbvs_pkg::WORDS_PER_BONE);

	assign vtx_in.ready = !vld_s1 || !q_full;
	assign push         = vld_s1 && !q_full;
	assign push_entry   = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (vtx_in.ready) begin
			vld_s1 <= vtx_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (vtx_in.valid && vtx_in.ready) begin
			entry_s1.wr_ok   <= wr_ok;
			entry_s1.wr_bone <= bone;
			entry_s1.wr_elem <= elem_wide[3:0];
			entry_s1.item    <= vtx_in.data;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/fbvs_queue.sv */
// Short FIFO that decouples the front end from the skinning back end.
// Depends on fbvs_pkg.
`default_nettype none

module fbvs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fbvs_pkg::q_entry_t  push_entry,
	output logic                full,
	output logic                head_vld,
	output fbvs_pkg::q_entry_t  head,
	input  logic                pop
);

	localparam int PW = $clog2(fbvs_pkg::QUEUE_DEPTH);

	fbvs_pkg::q_entry_t entries_q [fbvs_pkg::QUEUE_DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [PW:0]        count_q;

	assign full     = count_q == (PW + 1)'(fbvs_pkg::QUEUE_DEPTH);
	assign head_vld = count_q != '0;
	assign head     = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_vld)
		else $error("queue pop while empty");

endmodule

`default_nettype wire

/* hw/rtl/fbvs_div255.sv */
// Pipelined signed divide by 255 with rounding and 32-bit saturation.
// Depends on fbvs_pkg.
`default_nettype none

module fbvs_div255 (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] sum,
	output logic signed [31:0] quot
);

	logic        neg_s6, neg_s7, neg_s8, neg_s9;
	logic [63:0] y_s6, y_s7, y_s8;
	logic [63:0] pair_s7 [4];
	logic [55:0] q0_s8, q_s9;
	logic [63:0] mag;
	logic [63:0] tsum;
	logic [63:0] rem;
	logic [31:0] quot_s10;

	assign mag  = sum[63] ? (64'd0 - 64'(sum)) : 64'(sum);
	assign tsum = pair_s7[0] + pair_s7[1] + pair_s7[2] + pair_s7[3];
	// remainder after the series estimate; estimate is low by at most one
	assign rem  = y_s8 - ({8'd0, q0_s8} << 8) + {8'd0, q0_s8};

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s6 <= sum[63];
			y_s6   <= mag + fbvs_pkg::DIV_BIAS;

			neg_s7 <= neg_s6;
			y_s7   <= y_s6;
			for (int k = 0; k < 4; k++) begin
				pair_s7[k] <= (y_s6 >> (16 * k)) + (y_s6 >> (16 * k + 8));
			end

			neg_s8 <= neg_s7;
			y_s8   <= y_s7;
			q0_s8  <= tsum[63:8];

			neg_s9 <= neg_s8;
			q_s9   <= (rem >= fbvs_pkg::DIV_CONST) ? q0_s8 + 1'b1 : q0_s8;

			if (neg_s9) begin
				quot_s10 <= (q_s9 > fbvs_pkg::SAT_NEG_Q) ? fbvs_pkg::SAT_MIN
					: 32'(56'd0 - q_s9);
			end else begin
				quot_s10 <= (q_s9 > fbvs_pkg::SAT_POS_Q) ? fbvs_pkg::SAT_MAX
					: q_s9[31:0];
			end
		end
	end

	assign quot = $signed(quot_s10);

endmodule

`default_nettype wire

/* hw/rtl/fbvs_back.sv */
// Back end: palette memory, per-influence transform pipeline, accumulation, output.
// Depends on fbvs_pkg, fbvs_chan_if and fbvs_div255.
`default_nettype none

module fbvs_back #(
	parameter int BONE_COUNT = 256,
	parameter int INFLUENCES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_vld,
	input  fbvs_pkg::q_entry_t  head,
	output logic                pop,
	fbvs_chan_if.source         skin_out
);

	localparam int BW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
	localparam int IW = (INFLUENCES > 1) ? $clog2(INFLUENCES) : 1;

	function automatic logic signed [47:0] rnd_q16(input logic signed [63:0] p);
		logic signed [63:0] b;
		b = p + fbvs_pkg::ROUND_HALF;
		return $signed(b[63:16]);
	endfunction

	fbvs_pkg::bone_row_t pal_mem [BONE_COUNT];

	logic          adv, is_skin, issue, last_infl, bone_ok;
	logic [IW-1:0] infl_q;
	logic [IW+2:0] sh;
	logic [7:0]    w_sel, bone_sel;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic first_s1, first_s2, first_s3, first_s4;
	logic lasti_s1, lasti_s2, lasti_s3, lasti_s4;
	logic be_s1, be_s2, be_s3, be_s4, be_s5;
	logic be_s6, be_s7, be_s8, be_s9, be_s10;
	logic [7:0] w_s1, w_s2, w_s3;

	fbvs_pkg::bone_row_t row_s1;
	logic signed [31:0] pos_s1 [3];
	logic signed [31:0] norm_s1 [3];
	logic signed [63:0] prod_p_s2 [3][3];
	logic signed [63:0] prod_n_s2 [3][3];
	logic signed [31:0] trans_s2 [3];
	logic signed [49:0] tp_c [3];
	logic signed [49:0] tn_c [3];
	logic signed [49:0] tp_s3 [3];
	logic signed [49:0] tn_s3 [3];
	logic signed [63:0] wt_s4 [6];
	logic signed [63:0] acc_q [6];
	logic signed [31:0] quot [6];

	assign adv       = !vld_s10 || skin_out.ready;
	assign is_skin   = head.item.command == fbvs_pkg::CMD_SKIN;
	assign last_infl = infl_q == IW'(INFLUENCES - 1);
	assign issue     = adv && head_vld && is_skin;
	assign pop       = adv && head_vld && (!is_skin || last_infl);

	// influences past the packed bytes shift out to zero weight
	assign sh       = {infl_q, 3'b000};
	assign w_sel    = 8'(head.item.bone_weights >> sh);
	assign bone_sel = 8'(head.item.bone_indices >> sh);
	assign bone_ok  = {1'b0, bone_sel} < 9'(BONE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infl_q <= '0;
		end else if (issue) begin
			infl_q <= last_infl ? '0 : infl_q + 1'b1;
		end
	end

	// palette: one word written per load within the palette, one bone row read per influence
	always_ff @(posedge clk) begin
		if (adv && head_vld && !is_skin && head.wr_ok) begin
			pal_mem[BW'(head.wr_bone)][head.wr_elem] <= head.item.palette_word_value;
		end
		if (adv) begin
			row_s1 <= pal_mem[BW'(bone_sel)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= issue;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4 && lasti_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			tp_c[r] = {{2{trans_s2[r][31]}}, trans_s2[r], 16'h0000};
			tn_c[r] = '0;
			for (int c = 0; c < 3; c++) begin
				tp_c[r] = tp_c[r] + 50'(rnd_q16(prod_p_s2[r][c]));
				tn_c[r] = tn_c[r] + 50'(rnd_q16(prod_n_s2[r][c]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1   <= infl_q == '0;
			lasti_s1   <= last_infl;
			be_s1      <= head.item.last_vertex;
			w_s1       <= bone_ok ? w_sel : 8'd0;
			pos_s1[0]  <= head.item.pos_x;
			pos_s1[1]  <= head.item.pos_y;
			pos_s1[2]  <= head.item.pos_z;
			norm_s1[0] <= head.item.norm_x;
			norm_s1[1] <= head.item.norm_y;
			norm_s1[2] <= head.item.norm_z;

			first_s2 <= first_s1;
			lasti_s2 <= lasti_s1;
			be_s2    <= be_s1;
			w_s2     <= w_s1;
			for (int r = 0; r < 3; r++) begin
				trans_s2[r] <= $signed(row_s1[r * fbvs_pkg::ROW_WORDS + 3]);
				for (int c = 0; c < 3; c++) begin
					prod_p_s2[r][c] <= 64'($signed(row_s1[r * fbvs_pkg::ROW_WORDS + c]))
						* 64'(pos_s1[c]);
					prod_n_s2[r][c] <= 64'($signed(row_s1[r * fbvs_pkg::ROW_WORDS + c]))
						* 64'(norm_s1[c]);
				end
			end

			first_s3 <= first_s2;
			lasti_s3 <= lasti_s2;
			be_s3    <= be_s2;
			w_s3     <= w_s2;
			tp_s3    <= tp_c;
			tn_s3    <= tn_c;

			// a zero weight drops the influence whatever the row held
			first_s4 <= first_s3;
			lasti_s4 <= lasti_s3;
			be_s4    <= be_s3;
			for (int r = 0; r < 3; r++) begin
				wt_s4[r]     <= (w_s3 == 8'd0) ? 64'sd0
					: 64'(tp_s3[r]) * 64'($signed({1'b0, w_s3}));
				wt_s4[r + 3] <= (w_s3 == 8'd0) ? 64'sd0
					: 64'(tn_s3[r]) * 64'($signed({1'b0, w_s3}));
			end

			be_s5 <= be_s4;
			if (vld_s4) begin
				for (int i = 0; i < 6; i++) begin
					acc_q[i] <= first_s4 ? wt_s4[i] : acc_q[i] + wt_s4[i];
				end
			end

			be_s6  <= be_s5;
			be_s7  <= be_s6;
			be_s8  <= be_s7;
			be_s9  <= be_s8;
			be_s10 <= be_s9;
		end
	end

	for (genvar i = 0; i < 6; i++) begin : g_div
		fbvs_div255 u_div (
			.clk  (clk),
			.en   (adv),
			.sum  (acc_q[i]),
			.quot (quot[i])
		);
	end

	assign skin_out.valid           = vld_s10;
	assign skin_out.data.skinned_x  = quot[0];
	assign skin_out.data.skinned_y  = quot[1];
	assign skin_out.data.skinned_z  = quot[2];
	assign skin_out.data.skinned_nx = quot[3];
	assign skin_out.data.skinned_ny = quot[4];
	assign skin_out.data.skinned_nz = quot[5];
	assign skin_out.data.batch_end  = be_s10;

	a_infl_on_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		(infl_q != '0) |-> (head_vld && head.item.command == fbvs_pkg::CMD_SKIN))
		else $error("influence count running without a vertex at the queue head");
	a_sum_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s5) |-> $past(vld_s4 && lasti_s4))
		else $error("blend sum released before the last influence");

endmodule

`default_nettype wire

/* tb/fbvs_tb_chan_note.sv */
// Testbench helper package: rounding and blend helpers for the skinning predictor.
// Depends on fbvs_pkg.
`default_nettype none

package fbvs_tb_pkg;

	localparam int PALETTE_WORDS = 256 * fbvs_pkg::WORDS_PER_BONE;

	// floor((a*b + 2^15) / 2^16)
	function automatic longint q16_product(longint a, longint b);
		longint s;
		s = a * b + 64'sd32768;
		return s >>> 16;
	endfunction

	function automatic logic [31:0] blend_to_word(longint s);
		longint unsigned mag;
		longint unsigned q;
		mag = (s < 0) ? longint'(-s) : longint'(s);
		q = (mag + 127) / 255;
		if (s < 0) begin
			if (q > 64'h80000000) return fbvs_pkg::SAT_MIN;
			return 32'(-longint'(q));
		end
		if (q > 64'h7FFFFFFF) return fbvs_pkg::SAT_MAX;
		return 32'(q);
	endfunction
endpackage

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench of the four-bone vertex skinning unit.
// Depends on fbvs_pkg, fbvs_chan_if, fbvs_tb_pkg and the unit's RTL.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	longint cycle = 0;
	int errors = 0;
	int sent_words = 0;
	int sent_vertices = 0;
	int checked = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;

	logic [31:0]         palette_copy [fbvs_tb_pkg::PALETTE_WORDS];
	bit                  written [fbvs_tb_pkg::PALETTE_WORDS];
	int                  written_bones [$];
	fbvs_pkg::skin_out_t pending_skins [$];

	fbvs_chan_if #(.payload_t(fbvs_pkg::vtx_in_t))   vtx_in ();
	fbvs_chan_if #(.payload_t(fbvs_pkg::skin_out_t)) skin_out ();

	four_bone_vertex_skinning_unit i_dut (
		.clk(clk), .arst_n(arst_n), .vtx_in(vtx_in), .skin_out(skin_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		vtx_in.valid = 1'b0;
		vtx_in.data = '0;
		skin_out.ready = 1'b0;
	end

	// Bound the run and count cycles.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 400000) begin
			$display("four_bone_vertex_skinning_unit: mismatch");
			$finish;
		end
	end

	// Predict one vertex against the testbench's copy of the palette.
	function automatic fbvs_pkg::skin_out_t skin_vertex(fbvs_pkg::vtx_in_t v);
		fbvs_pkg::skin_out_t r;
		longint p [3];
		longint n [3];
		longint acc_p [3];
		longint acc_n [3];
		longint tp;
		longint tn;
		longint m;
		int w;
		int bone;
		p = '{v.pos_x, v.pos_y, v.pos_z};
		n = '{v.norm_x, v.norm_y, v.norm_z};
		acc_p = '{0, 0, 0};
		acc_n = '{0, 0, 0};
		for (int b = 0; b < 4; b++) begin
			w = int'(v.bone_weights[8*b +: 8]);
			bone = int'(v.bone_indices[8*b +: 8]);
			if (w != 0) begin
				for (int row = 0; row < 3; row++) begin
					tp = longint'($signed(palette_copy[bone*12 + row*4 + 3])) * 65536;
					tn = 0;
					for (int c = 0; c < 3; c++) begin
						m = $signed(palette_copy[bone*12 + row*4 + c]);
						tp += fbvs_tb_pkg::q16_product(m, p[c]);
						tn += fbvs_tb_pkg::q16_product(m, n[c]);
					end
					acc_p[row] += tp * w;
					acc_n[row] += tn * w;
				end
			end
		end
		r.skinned_x = fbvs_tb_pkg::blend_to_word(acc_p[0]);
		r.skinned_y = fbvs_tb_pkg::blend_to_word(acc_p[1]);
		r.skinned_z = fbvs_tb_pkg::blend_to_word(acc_p[2]);
		r.skinned_nx = fbvs_tb_pkg::blend_to_word(acc_n[0]);
		r.skinned_ny = fbvs_tb_pkg::blend_to_word(acc_n[1]);
		r.skinned_nz = fbvs_tb_pkg::blend_to_word(acc_n[2]);
		r.batch_end = v.last_vertex;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("ERROR cycle %0d skin %0d %s: got %h want %h", cycle, checked, what, got, want);
	endtask

	// Drive one word; advance only once it is taken. Valid stays up after the
	// last word until the next word, an idle cycle or the drain drops it.
	task automatic send_word(fbvs_pkg::vtx_in_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			vtx_in.valid <= 1'b0;
			@(posedge clk);
		end
		vtx_in.valid <= 1'b1;
		vtx_in.data <= v;
		@(posedge clk);
		while (!vtx_in.ready) @(posedge clk);
		sent_words++;
		if (v.command == fbvs_pkg::CMD_LOAD) begin
			if (v.palette_word_index < fbvs_tb_pkg::PALETTE_WORDS) begin
				palette_copy[v.palette_word_index] = v.palette_word_value;
				if (!written[v.palette_word_index]) begin
					written[v.palette_word_index] = 1'b1;
					if (v.palette_word_index % 12 == 11)
						written_bones.push_back(v.palette_word_index / 12);
				end
			end
		end else begin
			sent_vertices++;
			pending_skins.push_back(skin_vertex(v));
		end
	endtask

	// Receiver: stall at random, hold off for long stretches on request.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			skin_out.ready <= 1'b0;
		end else
			skin_out.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each accepted skin word with the oldest prediction.
	always @(posedge clk) begin
		fbvs_pkg::skin_out_t want;
		fbvs_pkg::skin_out_t got;
		if (arst_n && skin_out.valid && skin_out.ready) begin
			got = skin_out.data;
			if (pending_skins.size() == 0) begin
				errors++;
				$display("ERROR cycle %0d: skin word with none predicted", cycle);
			end else begin
				want = pending_skins.pop_front();
				if (got.skinned_x !== want.skinned_x)
					report_mismatch("x", got.skinned_x, want.skinned_x);
				if (got.skinned_y !== want.skinned_y)
					report_mismatch("y", got.skinned_y, want.skinned_y);
				if (got.skinned_z !== want.skinned_z)
					report_mismatch("z", got.skinned_z, want.skinned_z);
				if (got.skinned_nx !== want.skinned_nx)
					report_mismatch("nx", got.skinned_nx, want.skinned_nx);
				if (got.skinned_ny !== want.skinned_ny)
					report_mismatch("ny", got.skinned_ny, want.skinned_ny);
				if (got.skinned_nz !== want.skinned_nz)
					report_mismatch("nz", got.skinned_nz, want.skinned_nz);
				if (got.batch_end !== want.batch_end)
					report_mismatch("batch_end", 32'(got.batch_end), 32'(want.batch_end));
			end
			checked++;
		end
	end

	function automatic logic [31:0] rand_q16();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(32'h0003_0000) - 32'h0001_8000;
			default: return $urandom;
		endcase
	endfunction

	task automatic load_bone(int bone, bit extreme);
		fbvs_pkg::vtx_in_t v;
		for (int e = 0; e < 12; e++) begin
			v = '0;
			v.command = fbvs_pkg::CMD_LOAD;
			v.palette_word_index = 12'(bone*12 + e);
			v.palette_word_value = extreme
				? ($urandom_range(1) ? fbvs_pkg::SAT_MAX : fbvs_pkg::SAT_MIN)
				: rand_q16();
			v.bone_indices = $urandom;
			send_word(v);
		end
	endtask

	// Build a vertex whose weighted influences only touch written bones.
	function automatic fbvs_pkg::vtx_in_t make_vertex(bit wild);
		fbvs_pkg::vtx_in_t v;
		v = '0;
		v.command = fbvs_pkg::CMD_SKIN;
		v.palette_word_index = 12'($urandom);
		v.palette_word_value = $urandom;
		v.pos_x = rand_q16(); v.pos_y = rand_q16(); v.pos_z = rand_q16();
		v.norm_x = rand_q16(); v.norm_y = rand_q16(); v.norm_z = rand_q16();
		v.last_vertex = 1'($urandom_range(1));
		for (int b = 0; b < 4; b++) begin
			v.bone_indices[8*b +: 8] =
				8'(written_bones[$urandom_range(written_bones.size()-1)]);
			case ($urandom_range(3))
				0: v.bone_weights[8*b +: 8] = 8'd0;
				1: v.bone_weights[8*b +: 8] = 8'd255;
				default: v.bone_weights[8*b +: 8] = 8'($urandom);
			endcase
			if (v.bone_weights[8*b +: 8] == 0 && wild)
				v.bone_indices[8*b +: 8] = 8'($urandom);
		end
		return v;
	endfunction

	task automatic wait_drained();
		vtx_in.valid <= 1'b0;
		while (pending_skins.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		fbvs_pkg::vtx_in_t v;
		// Identity on bone 0, extremes on bone 255.
		for (int e = 0; e < 12; e++) begin
			v = '0;
			v.command = fbvs_pkg::CMD_LOAD;
			v.palette_word_index = 12'(e);
			v.palette_word_value = (e % 5 == 0) ? 32'h0001_0000 : 32'h0;
			send_word(v);
		end
		load_bone(255, 1'b1);
		// Load past the palette end: ignored.
		v = '0;
		v.command = fbvs_pkg::CMD_LOAD;
		v.palette_word_index = 12'hFFF;
		v.palette_word_value = 32'hFFFF_FFFF;
		send_word(v);
		v = make_vertex(1'b0);
		v.bone_weights = 32'h0000_00FF;
		v.bone_indices = 32'h0;
		send_word(v);
		// Saturate: full weight on all four influences of the extreme bone.
		v.bone_weights = 32'hFFFF_FFFF;
		v.bone_indices = 32'hFFFF_FFFF;
		v.pos_x = fbvs_pkg::SAT_MAX; v.pos_y = fbvs_pkg::SAT_MAX; v.pos_z = fbvs_pkg::SAT_MIN;
		v.norm_x = fbvs_pkg::SAT_MIN; v.norm_y = fbvs_pkg::SAT_MIN;
		v.norm_z = fbvs_pkg::SAT_MAX;
		v.last_vertex = 1'b1;
		send_word(v);
		// All weights zero, any bone numbers: zero output.
		v.bone_weights = 32'h0;
		v.bone_indices = $urandom;
		send_word(v);
		for (int k = 0; k < 4; k++) send_word(make_vertex(1'b1));
		wait_drained();
	endtask

	task automatic test_random(int count, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) == 0 && written_bones.size() < 256)
				load_bone($urandom_range(255), 1'b0);
			else
				send_word(make_vertex(1'($urandom_range(1))));
		end
		wait_drained();
	endtask

	// Hold the receiver off so the queue fills and input stalls.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 200;
		for (int k = 0; k < 20; k++) send_word(make_vertex(1'b1));
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(45, 0, 0);
		test_random(45, 63, 0);
		test_random(45, 0, 63);
		test_random(45, 25, 25);
		test_backpressure();
		repeat (50) @(posedge clk);
		$display("Covered %0d words in, %0d vertices, %0d skin words checked, %0d bones.",
			sent_words, sent_vertices, checked, written_bones.size());
		if (errors == 0 && pending_skins.size() == 0)
			$display("four_bone_vertex_skinning_unit: match");
		else
			$display("four_bone_vertex_skinning_unit: mismatch");
		$finish;
	end
endmodule

`default_nettype wire
